// ----- rtl/owbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the one-wire bus master
// Holds the command and phase encodings, the item type that travels from
// the front part to the sequencer, and the default bus timing values.
// ----------------------------------------------------------------------------
package owbm_pkg;

	// Operation codes as they arrive on the op field.
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Default timing of the reset sequence, in microseconds.
	localparam int RESET_LOW_US_DEF       = 480;
	localparam int PRESENCE_SAMPLE_US_DEF = 70;

	// Fixed phase lengths, in microseconds.
	localparam int RST_REL_US  = 50;
	localparam int RST_HOLD_US = 410;
	localparam int WR_START_US = 3;
	localparam int WR_ONE_US   = 55;
	localparam int WR_ZERO_US  = 60;
	localparam int WR_REC_US   = 1;
	localparam int RD_START_US = 3;
	localparam int RD_WAIT_US  = 3;
	localparam int RD_REST_US  = 45;

	// Depth of the queue between the front part and the sequencer.
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// Command class decided by the front part.
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_RESET,
		CMD_WRITE,
		CMD_READ
	} cmd_t;

	// Bus sequence phases.
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_REL,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_HOLD_OK,
		PH_RST_HOLD_BAD,
		PH_WR_START,
		PH_WR_ONE,
		PH_WR_ZERO,
		PH_WR_REC,
		PH_RD_START,
		PH_RD_WAIT,
		PH_RD_REST
	} phase_t;

	// One classified item as held in the queue.
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data;
		logic       line;
	} item_t;

	// Handshake between queue and sequencer.
	typedef struct packed {
		logic valid;
		item_t item;
	} q_out_t;

endpackage : owbm_pkg
`default_nettype wire

// ----- rtl/owbm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_front: input acceptance, command classification and item queue
// Takes one item per cycle while not stalled, turns the op code into a command
// class and holds the item in a short queue until the sequencer takes it.
// ----------------------------------------------------------------------------
module owbm_front import owbm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] op,
	input  wire logic [7:0] data_byte,
	input  wire logic       line_in,
	input  wire logic       in_valid,
	output logic            in_stall,
	output q_out_t          q_out,
	input  wire logic       q_pop
);

	item_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	item_t              item_new;
	logic               push;
	logic               pop;

	// Classify the op code of the incoming item.
	always_comb begin
		item_new.data = data_byte;
		item_new.line = line_in;
		case (op)
			OP_NONE:  item_new.cmd = CMD_NONE;
			OP_RESET: item_new.cmd = CMD_RESET;
			OP_WRITE: item_new.cmd = CMD_WRITE;
			OP_READ:  item_new.cmd = CMD_READ;
			default:  item_new.cmd = CMD_NONE;
		endcase
	end

	// The queue refuses new items only when every slot is taken.
	assign in_stall = (count_q == QCNT_W'(Q_DEPTH));
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && (count_q != '0);

	// Item storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_new;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign q_out.valid = (count_q != '0);
	assign q_out.item  = mem_q[rd_ptr_q];

endmodule : owbm_front
`default_nettype wire

// ----- rtl/owbm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_back: bus sequencer and result register
// Advances the reset, write and read sequences by one tick per item taken
// from the queue and registers the result item for the output channel.
// ----------------------------------------------------------------------------
module owbm_back import owbm_pkg::*; #(
	parameter int RESET_LOW_US       = RESET_LOW_US_DEF,
	parameter int PRESENCE_SAMPLE_US = PRESENCE_SAMPLE_US_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] tpu,
	input  q_out_t          q_out,
	output logic            q_pop,
	output logic            drive_low,
	output logic            busy_res,
	output logic            done_res,
	output logic            presence,
	output logic [7:0]      read_data,
	output logic            cmd_rejected,
	output logic            out_valid,
	input  wire logic       out_stall
);

	localparam int MAX_US = (RESET_LOW_US > RST_HOLD_US) ? RESET_LOW_US : RST_HOLD_US;
	localparam int CNT_W  = $clog2(MAX_US + 1);

	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc, len;
	logic [7:0]         presc_q, presc_d, presc_inc, limit;
	logic [2:0]         bit_q, bit_d;
	logic [7:0]         shift_q, shift_d;
	logic               pres_q, pres_d;
	logic [7:0]         rdres_q, rdres_d;
	logic               done_d, rej_d, drive_d;
	logic               out_valid_q;
	item_t              it;

	assign it    = q_out.item;
	assign q_pop = q_out.valid && (!out_valid_q || !out_stall);

	// Length of the current phase in microseconds.
	always_comb begin
		case (phase_q)
			PH_RST_REL:      len = CNT_W'(RST_REL_US);
			PH_RST_LOW:      len = CNT_W'(RESET_LOW_US);
			PH_RST_WAIT:     len = CNT_W'(PRESENCE_SAMPLE_US);
			PH_RST_HOLD_OK:  len = CNT_W'(RST_HOLD_US);
			PH_RST_HOLD_BAD: len = CNT_W'(RST_HOLD_US);
			PH_WR_START:     len = CNT_W'(WR_START_US);
			PH_WR_ONE:       len = CNT_W'(WR_ONE_US);
			PH_WR_ZERO:      len = CNT_W'(WR_ZERO_US);
			PH_WR_REC:       len = CNT_W'(WR_REC_US);
			PH_RD_START:     len = CNT_W'(RD_START_US);
			PH_RD_WAIT:      len = CNT_W'(RD_WAIT_US);
			PH_RD_REST:      len = CNT_W'(RD_REST_US);
			default:         len = CNT_W'(1);
		endcase
	end

	assign limit     = (tpu == 8'd0) ? 8'd1 : tpu;
	assign presc_inc = presc_q + 8'd1;
	assign cnt_inc   = cnt_q + 1'b1;

	// Next state of the sequencer for one tick.
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		presc_d = presc_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		pres_d  = pres_q;
		rdres_d = rdres_q;
		done_d  = 1'b0;
		rej_d   = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (it.cmd != CMD_NONE) begin
				cnt_d   = '0;
				presc_d = '0;
				bit_d   = '0;
				case (it.cmd)
					CMD_RESET: phase_d = PH_RST_REL;
					CMD_WRITE: begin
						shift_d = it.data;
						phase_d = PH_WR_START;
					end
					CMD_READ: begin
						shift_d = '0;
						phase_d = PH_RD_START;
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end else begin
			rej_d = (it.cmd != CMD_NONE);
			if (presc_inc >= limit || presc_inc == 8'd0) begin
				presc_d = '0;
				if (cnt_inc >= len) begin
					cnt_d = '0;
					// Phase has run out: move to the following one.
					case (phase_q)
						PH_RST_REL:  phase_d = PH_RST_LOW;
						PH_RST_LOW:  phase_d = PH_RST_WAIT;
						PH_RST_WAIT: phase_d = it.line ? PH_RST_HOLD_BAD : PH_RST_HOLD_OK;
						PH_RST_HOLD_OK: begin
							pres_d  = it.line;
							phase_d = PH_IDLE;
							bit_d   = '0;
							done_d  = 1'b1;
						end
						PH_RST_HOLD_BAD: begin
							pres_d  = 1'b0;
							phase_d = PH_IDLE;
							bit_d   = '0;
							done_d  = 1'b1;
						end
						PH_WR_START: phase_d = shift_q[0] ? PH_WR_ONE : PH_WR_ZERO;
						PH_WR_ZERO:  phase_d = PH_WR_REC;
						PH_WR_ONE, PH_WR_REC: begin
							if (bit_q == 3'd7) begin
								phase_d = PH_IDLE;
								bit_d   = '0;
								done_d  = 1'b1;
							end else begin
								bit_d   = bit_q + 3'd1;
								shift_d = {1'b0, shift_q[7:1]};
								phase_d = PH_WR_START;
							end
						end
						PH_RD_START: phase_d = PH_RD_WAIT;
						PH_RD_WAIT: begin
							shift_d = {it.line, shift_q[7:1]};
							phase_d = PH_RD_REST;
						end
						PH_RD_REST: begin
							if (bit_q == 3'd7) begin
								rdres_d = shift_q;
								phase_d = PH_IDLE;
								bit_d   = '0;
								done_d  = 1'b1;
							end else begin
								bit_d   = bit_q + 3'd1;
								phase_d = PH_RD_START;
							end
						end
						default: begin
							phase_d = PH_IDLE;
							bit_d   = '0;
							done_d  = 1'b1;
						end
					endcase
				end else begin
					cnt_d = cnt_inc;
				end
			end else begin
				presc_d = presc_inc;
			end
		end
		drive_d = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_START) ||
			(phase_d == PH_WR_ZERO) || (phase_d == PH_RD_START);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			presc_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			rdres_q <= '0;
		end else if (q_pop) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			presc_q <= presc_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			rdres_q <= rdres_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			drive_low    <= drive_d;
			busy_res     <= (phase_d != PH_IDLE);
			done_res     <= done_d;
			presence     <= pres_d;
			read_data    <= rdres_d;
			cmd_rejected <= rej_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule : owbm_back
`default_nettype wire

// ----- rtl/one_wire_bus_master_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master_top: one-wire bus master, standard speed
// Each item is one clock tick of bus timing; op starts a reset, write byte
// or read byte sequence and the result item reports the bus drive and status.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    op, data_byte, line_in
//   output    out_valid / out_stall  drive_low, busy_res, done_res, presence,
//                                    read_data, cmd_rejected
//   config    cfg_valid / cfg_ready  cfg_data (ticks per microsecond)
//
// One item is taken per cycle while the queue has room; its result is offered
// once it has passed the two-entry queue and the sequencer's result register.
// The sequencer updates all its state at once for each item it takes.
// Reset clears the sequencer to idle and sets ticks per microsecond to 1.
// A stalled output holds the sequencer; the queue then fills and stalls input.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top import owbm_pkg::*; #(
	parameter int RESET_LOW_US       = RESET_LOW_US_DEF,
	parameter int PRESENCE_SAMPLE_US = PRESENCE_SAMPLE_US_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] op,
	input  wire logic [7:0] data_byte,
	input  wire logic       line_in,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            drive_low,
	output logic            busy_res,
	output logic            done_res,
	output logic            presence,
	output logic [7:0]      read_data,
	output logic            cmd_rejected
);

	logic [7:0] tpu_q;
	q_out_t     q_out;
	logic       q_pop;

	// Ticks per microsecond register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			tpu_q <= cfg_data;
		end
	end

	owbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.data_byte (data_byte),
		.line_in   (line_in),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.q_out     (q_out),
		.q_pop     (q_pop)
	);

	owbm_back #(
		.RESET_LOW_US       (RESET_LOW_US),
		.PRESENCE_SAMPLE_US (PRESENCE_SAMPLE_US)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tpu          (tpu_q),
		.q_out        (q_out),
		.q_pop        (q_pop),
		.drive_low    (drive_low),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.presence     (presence),
		.read_data    (read_data),
		.cmd_rejected (cmd_rejected),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

endmodule : one_wire_bus_master_top
`default_nettype wire

// ----- rtl/owbm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_checker: port-level checks of the one-wire bus master
// Watches the top level's ports and flags results that break the bus
// sequencing rules or the flow between input and output.
// ----------------------------------------------------------------------------
module owbm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic [7:0] cfg_data,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] op,
	input wire logic [7:0] data_byte,
	input wire logic       line_in,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       drive_low,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic       presence,
	input wire logic [7:0] read_data,
	input wire logic       cmd_rejected
);

	// A stalled result item stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) &&
		$stable(done_res) && $stable(busy_res) && $stable(drive_low))
		else $error("stalled result item changed");

	// A finished sequence leaves the master idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// The line is only pulled low inside a sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_low |-> busy_res)
		else $error("line driven low while idle");

	// Input can only back up behind a waiting result item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

endmodule : owbm_checker

bind one_wire_bus_master_top owbm_checker u_owbm_checker (.*);
`default_nettype wire
